[design/lut_entry_momentum_update_top_assert.svh]
// Assertion macros shared by the momentum update checker.
`ifndef LUT_ENTRY_MOMENTUM_UPDATE_TOP_ASSERT_SVH
`define LUT_ENTRY_MOMENTUM_UPDATE_TOP_ASSERT_SVH

// Clocked assertion, masked while reset is asserted.
`define LEMU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define LEMU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/lemu_pkg.sv]
// Package: widths, register codes, sideband type and saturation helper.
package lemu_pkg;

  localparam int DEF_COUNT_BITS = 24;
  localparam int DATA_W         = 32;
  localparam int COEF_W         = 16;
  localparam int PROD_W         = 48;
  localparam int CFG_ADDR_W     = 5;

  typedef enum logic [2:0] {
    REG_RATE   = 3'd0,
    REG_BETA   = 3'd1,
    REG_LAMBDA = 3'd2,
    REG_MAXV   = 3'd3,
    REG_MINV   = 3'd4,
    REG_MAXCH  = 3'd5
  } reg_idx_t;

  // Data that rides alongside the divider pipeline.
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] grad;
    logic                     neg;
    logic                     zero;
    logic signed [DATA_W-1:0] l2;
    logic signed [PROD_W-1:0] mb;
  } side_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] x);
    logic signed [DATA_W+1:0] hi;
    logic signed [DATA_W+1:0] lo;
    hi = {3'b000, {(DATA_W-1){1'b1}}};
    lo = {3'b111, {(DATA_W-1){1'b0}}};
    if (x > hi) begin
      sat32 = hi[DATA_W-1:0];
    end else if (x < lo) begin
      sat32 = lo[DATA_W-1:0];
    end else begin
      sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage

[design/lemu_ifs.sv]
// Request and result channel interfaces.
interface lemu_in_if import lemu_pkg::*; #(parameter int COUNT_BITS = DEF_COUNT_BITS);
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] gradient_sum;
  logic [COUNT_BITS-1:0]    hit_count;
  logic signed [DATA_W-1:0] old_momentum;
  modport source(output valid, entry_value, gradient_sum, hit_count, old_momentum,
                 input ready);
  modport sink(input valid, entry_value, gradient_sum, hit_count, old_momentum,
               output ready);
endinterface

interface lemu_out_if import lemu_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_value;
  logic signed [DATA_W-1:0] new_momentum;
  logic                     change_clipped;
  modport source(output valid, new_value, new_momentum, change_clipped, input ready);
  modport sink(input valid, new_value, new_momentum, change_clipped, output ready);
endinterface

[design/lemu_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module lemu_div import lemu_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [DATA_W-1:0] in_mag,
  input  logic [COUNT_BITS-1:0] in_den,
  input  side_t             in_side,
  output logic              out_vld,
  output logic [DATA_W-1:0] out_quo,
  output side_t             out_side
);

  localparam int NS = DATA_W;

  logic                  vld_r  [NS];
  logic [COUNT_BITS-1:0] rem_r  [NS];
  logic [DATA_W-1:0]     dvd_r  [NS];
  logic [COUNT_BITS-1:0] den_r  [NS];
  side_t                 side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                  vld_i;
    logic [COUNT_BITS-1:0] rem_i;
    logic [DATA_W-1:0]     dvd_i;
    logic [COUNT_BITS-1:0] den_i;
    side_t                 side_i;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  qbit;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign dvd_i  = in_mag;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign dvd_i  = dvd_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      trial = {rem_i, dvd_i[DATA_W-1]};
      diff  = trial - {1'b0, den_i};
      qbit  = (trial >= {1'b0, den_i});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        dvd_r[k]  <= {dvd_i[DATA_W-2:0], qbit};
        den_r[k]  <= den_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_quo  = dvd_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

[design/lut_entry_momentum_update_top.sv]
// Pipeline: an input stage, 32 divider stages and 5 more stages from request to result.
// Throughput: one request per cycle; the whole pipeline holds while the result waits.
// The divider spends one stage per quotient bit, which sets the depth.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
module lut_entry_momentum_update_top import lemu_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lemu_in_if.sink               in_chan,
  lemu_out_if.source            out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers
  logic [COEF_W-1:0]        rate_r, beta_r, lambda_r;
  logic signed [DATA_W-1:0] maxv_r, minv_r;
  logic [DATA_W-2:0]        maxch_r;
  reg_idx_t                 cidx;
  logic                     cwr;

  assign cfg_pready = 1'b1;
  assign cidx = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cwr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= 16'd655;
      beta_r   <= 16'd58982;
      lambda_r <= '0;
      maxv_r   <= {1'b0, {(DATA_W-1){1'b1}}};
      minv_r   <= {1'b1, {(DATA_W-1){1'b0}}};
      maxch_r  <= '1;
    end else if (cwr) begin
      unique case (cidx)
        REG_RATE:   rate_r   <= cfg_pwdata[COEF_W-1:0];
        REG_BETA:   beta_r   <= cfg_pwdata[COEF_W-1:0];
        REG_LAMBDA: lambda_r <= cfg_pwdata[COEF_W-1:0];
        REG_MAXV:   maxv_r   <= cfg_pwdata[DATA_W-1:0];
        REG_MINV:   minv_r   <= cfg_pwdata[DATA_W-1:0];
        REG_MAXCH:  maxch_r  <= cfg_pwdata[DATA_W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cidx)
      REG_RATE:   cfg_prdata = {16'd0, rate_r};
      REG_BETA:   cfg_prdata = {16'd0, beta_r};
      REG_LAMBDA: cfg_prdata = {16'd0, lambda_r};
      REG_MAXV:   cfg_prdata = maxv_r;
      REG_MINV:   cfg_prdata = minv_r;
      REG_MAXCH:  cfg_prdata = {1'b0, maxch_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Global advance: hold everything while the result register is full and stalled.
  logic adv;
  assign adv = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = adv;

  // Stage P: operand magnitude and the two products that do not need the quotient.
  logic                     p_vld_r;
  logic [DATA_W-1:0]        p_mag_r;
  logic [COUNT_BITS-1:0]    p_den_r;
  side_t                    p_side_r;
  logic signed [PROD_W:0]   l_prod, mb_prod;
  logic signed [DATA_W:0]   g_ext;
  logic signed [DATA_W:0]   g_abs;

  always_comb begin
    l_prod  = in_chan.entry_value * $signed({1'b0, lambda_r});
    mb_prod = in_chan.old_momentum * $signed({1'b0, beta_r});
    g_ext   = {in_chan.gradient_sum[DATA_W-1], in_chan.gradient_sum};
    g_abs   = g_ext[DATA_W] ? -g_ext : g_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_mag_r       <= g_abs[DATA_W-1:0];
      p_den_r       <= in_chan.hit_count;
      p_side_r.val  <= in_chan.entry_value;
      p_side_r.grad <= in_chan.gradient_sum;
      p_side_r.neg  <= in_chan.gradient_sum[DATA_W-1];
      p_side_r.zero <= (in_chan.hit_count == '0);
      p_side_r.l2   <= l_prod[PROD_W-1:16];
      p_side_r.mb   <= mb_prod[PROD_W-1:0];
    end
  end

  logic              d_vld;
  logic [DATA_W-1:0] d_quo;
  side_t             d_side;

  lemu_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p_vld_r),
    .in_mag   (p_mag_r),
    .in_den   (p_den_r),
    .in_side  (p_side_r),
    .out_vld  (d_vld),
    .out_quo  (d_quo),
    .out_side (d_side)
  );

  // Stage Q: signed average plus L2 term.
  logic                     q_vld_r;
  logic signed [DATA_W-1:0] q_s_r, q_val_r;
  logic signed [PROD_W-1:0] q_mb_r;
  logic signed [DATA_W:0]   g_avg, q_mag;
  logic signed [DATA_W+1:0] s_sum;

  always_comb begin
    q_mag = $signed({1'b0, d_quo});
    if (d_side.zero) begin
      g_avg = {d_side.grad[DATA_W-1], d_side.grad};
    end else if (d_side.neg) begin
      g_avg = -q_mag;
    end else begin
      g_avg = q_mag;
    end
    s_sum = {g_avg[DATA_W], g_avg} + {{2{d_side.l2[DATA_W-1]}}, d_side.l2};
  end

  // Stage R: rate product.
  logic                     r_vld_r;
  logic signed [PROD_W-1:0] r_sr_r, r_mb_r;
  logic signed [DATA_W-1:0] r_val_r;
  logic signed [PROD_W:0]   sr_prod;

  assign sr_prod = q_s_r * $signed({1'b0, rate_r});

  // Stage T: momentum sum, floor shift, saturate.
  logic                     t_vld_r;
  logic signed [DATA_W-1:0] t_m_r, t_val_r;
  logic signed [PROD_W:0]   tot;

  assign tot = {r_mb_r[PROD_W-1], r_mb_r} + {r_sr_r[PROD_W-1], r_sr_r};

  // Stage U: clip momentum, subtract from value.
  logic                     u_vld_r, u_clip_r;
  logic signed [DATA_W-1:0] u_m_r, u_v_r;
  logic signed [DATA_W:0]   lim, nlim, m_ext;
  logic signed [DATA_W-1:0] m_clip;
  logic                     clip;
  logic signed [DATA_W+1:0] v_diff;

  always_comb begin
    lim   = {2'b00, maxch_r};
    nlim  = -lim;
    m_ext = {t_m_r[DATA_W-1], t_m_r};
    clip  = 1'b1;
    if (m_ext > lim) begin
      m_clip = lim[DATA_W-1:0];
    end else if (m_ext < nlim) begin
      m_clip = nlim[DATA_W-1:0];
    end else begin
      m_clip = t_m_r;
      clip   = 1'b0;
    end
    v_diff = {{2{t_val_r[DATA_W-1]}}, t_val_r} - {{2{m_clip[DATA_W-1]}}, m_clip};
  end

  // Stage W: clamp into the result register.
  logic                     w_vld_r, w_clip_r;
  logic signed [DATA_W-1:0] w_v_r, w_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      t_vld_r <= 1'b0;
      u_vld_r <= 1'b0;
      w_vld_r <= 1'b0;
    end else if (adv) begin
      q_vld_r <= d_vld;
      r_vld_r <= q_vld_r;
      t_vld_r <= r_vld_r;
      u_vld_r <= t_vld_r;
      w_vld_r <= u_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_s_r    <= sat32(s_sum);
      q_val_r  <= d_side.val;
      q_mb_r   <= d_side.mb;
      r_sr_r   <= sr_prod[PROD_W-1:0];
      r_mb_r   <= q_mb_r;
      r_val_r  <= q_val_r;
      t_m_r    <= sat32({tot[PROD_W], tot[PROD_W:16]});
      t_val_r  <= r_val_r;
      u_m_r    <= m_clip;
      u_clip_r <= clip;
      u_v_r    <= sat32(v_diff);
      w_m_r    <= u_m_r;
      w_clip_r <= u_clip_r;
      if (u_v_r > maxv_r) begin
        w_v_r <= maxv_r;
      end else if (u_v_r < minv_r) begin
        w_v_r <= minv_r;
      end else begin
        w_v_r <= u_v_r;
      end
    end
  end

  assign out_chan.valid          = w_vld_r;
  assign out_chan.new_value      = w_v_r;
  assign out_chan.new_momentum   = w_m_r;
  assign out_chan.change_clipped = w_clip_r;

endmodule

[design/lemu_checker.sv]
// Port-level checker for the momentum update block, with its bind.
`include "lut_entry_momentum_update_top_assert.svh"

module lemu_checker import lemu_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] new_momentum,
  input logic              change_clipped
);

  `LEMU_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `LEMU_ASSERT(a_ready_follows, in_ready == (!out_valid || out_ready), "ready not tied to result drain")
  `LEMU_ASSERT(a_no_min_mom, out_valid |-> new_momentum != {1'b1, {(DATA_W-1){1'b0}}}, "unclipped minimum momentum")
  `LEMU_ASSERT(a_hold_result, out_valid && !out_ready |=> out_valid && $stable(new_momentum) && $stable(change_clipped), "stalled result changed")

endmodule

bind lut_entry_momentum_update_top lemu_checker u_lemu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .new_momentum   (out_chan.new_momentum),
  .change_clipped (out_chan.change_clipped)
);

[tb/testbench.sv]
// Self-checking testbench for the lookup-table entry momentum update block.
module testbench;
  import lemu_pkg::*;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  lemu_in_if #(.COUNT_BITS(DEF_COUNT_BITS)) in_chan();
  lemu_out_if out_chan();

  lut_entry_momentum_update_top #(.COUNT_BITS(DEF_COUNT_BITS)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan.sink),
    .out_chan    (out_chan.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  localparam int LATENCY   = 38;
  localparam int WDOG_MAX  = 5000;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic signed [31:0] new_momentum;
    logic               change_clipped;
  } update_t;

  // Shadow copy of the register file
  logic [15:0]        rate_q;
  logic [15:0]        beta_q;
  logic [15:0]        lambda_q;
  logic signed [31:0] maxv_q;
  logic signed [31:0] minv_q;
  logic [30:0]        maxch_q;

  update_t pending_updates[$];
  int      errors = 0;
  int      quiet_cycles;
  bit      in_calm;
  bit      out_calm;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic update_t compute_update(input logic signed [31:0] val,
                                             input logic signed [31:0] grad,
                                             input logic [DEF_COUNT_BITS-1:0] hits,
                                             input logic signed [31:0] mom);
    logic signed [63:0] g;
    logic signed [63:0] l2;
    logic signed [63:0] s;
    logic signed [63:0] m;
    logic signed [63:0] v;
    logic signed [63:0] lim;
    update_t r;
    g = 64'(grad);
    if (hits != '0) begin
      g = g / $signed({40'd0, hits});
    end
    // arithmetic shift on signed 64-bit is floor division by 2^16
    l2 = (64'(val) * $signed({48'd0, lambda_q})) >>> 16;
    s = clamp32(g + l2);
    m = clamp32((64'(mom) * $signed({48'd0, beta_q}) + s * $signed({48'd0, rate_q})) >>> 16);
    lim = $signed({33'd0, maxch_q});
    r.change_clipped = 1'b0;
    if (m > lim) begin
      m = lim;
      r.change_clipped = 1'b1;
    end else if (m < -lim) begin
      m = -lim;
      r.change_clipped = 1'b1;
    end
    v = clamp32(64'(val) - m);
    if (v > 64'(maxv_q)) begin
      v = 64'(maxv_q);
    end else if (v < 64'(minv_q)) begin
      v = 64'(minv_q);
    end
    r.new_value = v[31:0];
    r.new_momentum = m[31:0];
    return r;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(idx));
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_RATE:   rate_q   = data[15:0];
      REG_BETA:   beta_q   = data[15:0];
      REG_LAMBDA: lambda_q = data[15:0];
      REG_MAXV:   maxv_q   = data;
      REG_MINV:   minv_q   = data;
      REG_MAXCH:  maxch_q  = data[30:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] rate, input logic [15:0] beta,
                          input logic [15:0] lambda, input logic [31:0] maxv,
                          input logic [31:0] minv, input logic [31:0] maxch);
    write_reg(REG_RATE, {16'd0, rate});
    write_reg(REG_BETA, {16'd0, beta});
    write_reg(REG_LAMBDA, {16'd0, lambda});
    write_reg(REG_MAXV, maxv);
    write_reg(REG_MINV, minv);
    write_reg(REG_MAXCH, maxch);
  endtask

  // Drive one request; called and returns on a falling edge with valid still up,
  // so the next call or drain decides what valid does at that edge
  task automatic send_entry(input logic [31:0] val, input logic [31:0] grad,
                            input logic [DEF_COUNT_BITS-1:0] hits, input logic [31:0] mom);
    while (!in_calm && $urandom_range(99) < 28) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.entry_value  <= val;
    in_chan.gradient_sum <= grad;
    in_chan.hit_count    <= hits;
    in_chan.old_momentum <= mom;
    do @(posedge clk); while (!in_chan.ready);
    pending_updates.push_back(compute_update(val, grad, hits, mom));
    @(negedge clk);
  endtask

  task automatic drain;
    in_chan.valid <= 1'b0;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DEF_COUNT_BITS-1:0] rand_hits();
    case ($urandom_range(3))
      0: return '0;
      1: return DEF_COUNT_BITS'($urandom_range(16));
      2: return '1;
      default: return DEF_COUNT_BITS'($urandom);
    endcase
  endfunction

  task automatic test_defaults;
    send_entry(32'h0001_0000, 32'h0004_0000, 24'd4, 32'h0000_8000);
    send_entry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd0, 32'h7FFF_FFFF);
    send_entry(32'h8000_0000, 32'h8000_0000, 24'd0, 32'h8000_0000);
    send_entry(32'h0000_0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'h0000_0000);
    send_entry(32'hFFFF_0000, 32'h8000_0000, 24'd3, 32'hFFFF_FFFF);
    send_entry(32'h1234_5678, 32'hF000_0001, 24'd7, 32'h8000_0001);
    drain();
  endtask

  task automatic test_extremes;
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000);
    send_entry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1, 32'h7FFF_FFFF);
    send_entry(32'h8000_0000, 32'h8000_0000, 24'd1, 32'h8000_0000);
    send_entry(32'h0000_1000, 32'h0000_0010, 24'd0, 32'h0000_0100);
    send_entry(32'hFFFF_F000, 32'hFFFF_FFF0, 24'd2, 32'hFFFF_FF00);
    drain();
    // an old momentum of -2^31 with full beta stays inside the widest limit, unclipped
    set_regs(16'd0, 16'hFFFF, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_entry(32'h0, 32'h0, 24'd0, 32'h8000_0000);
    drain();
    set_regs(16'hFFFF, 16'd0, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_entry(32'h0, 32'h8000_0000, 24'd0, 32'h0);
    drain();
    set_regs(16'd0, 16'd0, 16'd0, 32'h0, 32'h0, 32'h0);
    send_entry(32'h0001_0000, 32'h1, 24'd1, 32'h1);
    drain();
  endtask

  task automatic test_inverted_bounds;
    set_regs(16'd655, 16'd58982, 16'd100, 32'hFFFF_0000, 32'h0001_0000, 32'h0100_0000);
    send_entry(32'h0005_0000, 32'h0, 24'd0, 32'h0);
    send_entry(32'hFFFF_8000, 32'h0, 24'd0, 32'h0);
    send_entry(32'hFFF0_0000, 32'h0, 24'd0, 32'h0);
    drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        drain();
        set_regs(16'($urandom), 16'($urandom), 16'($urandom), rand_word(), rand_word(),
                 $urandom_range(3) == 0 ? 32'h7FFF_FFFF : $urandom);
      end
      in_calm  = (i % 400) >= 300;
      out_calm = in_calm;
      if (i == count / 2) begin
        // hold until the pipeline empties
        in_chan.valid <= 1'b0;
        do @(negedge clk); while (pending_updates.size() != 0);
      end
      send_entry(rand_word(), rand_word(), rand_hits(), rand_word());
    end
    in_calm  = 1'b0;
    out_calm = 1'b0;
    drain();
  endtask

  always @(negedge clk) begin
    out_chan.ready <= rst_n && (out_calm || ($urandom_range(99) >= 28));
  end

  always @(posedge clk) begin
    update_t exp_upd;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result value=%h momentum=%h clipped=%b", $time,
                 out_chan.new_value, out_chan.new_momentum, out_chan.change_clipped);
        errors++;
      end else begin
        exp_upd = pending_updates.pop_front();
        if (out_chan.new_value !== exp_upd.new_value) begin
          $display("%0t: new_value expected %h actual %h", $time, exp_upd.new_value,
                   out_chan.new_value);
          errors++;
        end
        if (out_chan.new_momentum !== exp_upd.new_momentum) begin
          $display("%0t: new_momentum expected %h actual %h", $time,
                   exp_upd.new_momentum, out_chan.new_momentum);
          errors++;
        end
        if (out_chan.change_clipped !== exp_upd.change_clipped) begin
          $display("%0t: change_clipped expected %b actual %b", $time,
                   exp_upd.change_clipped, out_chan.change_clipped);
          errors++;
        end
      end
    end
  end

  // Count cycles with no accepted request or result and no register access
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_chan.valid        = 1'b0;
    in_chan.entry_value  = '0;
    in_chan.gradient_sum = '0;
    in_chan.hit_count    = '0;
    in_chan.old_momentum = '0;
    rate_q   = 16'd655;
    beta_q   = 16'd58982;
    lambda_q = 16'd0;
    maxv_q   = 32'sh7FFF_FFFF;
    minv_q   = 32'sh8000_0000;
    maxch_q  = 31'h7FFF_FFFF;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_defaults();
    test_extremes();
    test_inverted_bounds();
    test_random(1400);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
